FILE: src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and codes for the lru key-value cache with expiry
// ----------------------------------------------------------------------------
`default_nettype none
package lkvc_pkg;
    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_DEL    = 3'd2,
        OP_EXISTS = 3'd3,
        OP_EXPIRE = 3'd4,
        OP_TTL    = 3'd5,
        OP_TYPE   = 3'd6,
        OP_TICK   = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [63:0]        key;
        logic [63:0]        value;
        logic signed [31:0] ttl_seconds;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [63:0]        read_value;
        logic signed [31:0] remaining_seconds;
        logic               present_type;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_RANK,
        ST_LRU,
        ST_LRUCHK,
        ST_FREE,
        ST_INS,
        ST_DONE
    } state_t;

    localparam int DL_BITS = 34;
endpackage
`default_nettype wire

FILE: src/lru_key_value_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_with_expiry
// fully associative key-value cache, lru replacement and per-key expiry
// ----------------------------------------------------------------------------
// channel   ports                        transfer
// request   start, busy, req             start && !busy
// result    done, rsp                    done, one cycle, no stall
// config    cfg_we, cfg_data             cfg_we
//
// a request scans the entry memory one address a cycle and compares each word
// the cycle after its read, until a hit or past the last entry. then ST_ACT
// acts on the entry, ST_RANK moves all ranks at once and ST_DONE raises done;
// a tick goes straight to ST_DONE. a set of a new key then passes ST_LRU,
// ST_LRUCHK and ST_FREE per lru check (at most ENTRIES+1) and ST_INS to
// insert. busy drops as done rises, so the next transfer can come at the edge
// that ends done.
// recency ranks and valid bits sit in flip-flops, payload sits in the entry
// memory; reset clears valid bits, clock and count. results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_key_value_cache_with_expiry #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output      logic           busy,
    input  wire lkvc_pkg::req_t req,
    output      logic           done,
    output      lkvc_pkg::rsp_t rsp,
    input  wire logic           cfg_we,
    input  wire logic [4:0]     cfg_data
);
    import lkvc_pkg::*;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int W  = KEY_BITS + VALUE_BITS + 1 + DL_BITS;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [4:0]    cfg_reg;
    logic [31:0]   clk_sec_reg;
    logic [CW-1:0] live_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IW-1:0] rank_reg [ENTRIES];
    logic [IW:0]   cnt_reg;
    logic          found_reg;
    logic [IW-1:0] hit_reg;
    logic [IW-1:0] tgt_reg;
    logic          rm_reg;      // rank pass removes target, else touches it
    logic          ins_reg;     // set of a new key still pending
    logic          sweep_reg;   // still sweeping expired entries at the lru tail
    rsp_t          rsp_reg;
    logic          done_reg;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [W-1:0]  wdata, rdata;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_has;
    logic signed [DL_BITS-1:0] r_dl;

    lkvc_store #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
        .IW(IW)) u_store (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata));

    assign {r_key, r_val, r_has, r_dl} = rdata;

    // derived values
    logic [4:0] lim;
    logic signed [DL_BITS-1:0] now_s, new_dl;
    logic expired;
    logic has_ttl;
    logic [IW:0] scan_prev;
    logic scan_hit;
    always_comb
    begin
        lim = cfg_reg;
        if (lim == 5'd0) lim = 5'd1;
        if (32'(lim) > ENTRIES) lim = 5'(ENTRIES);
        now_s   = DL_BITS'({2'b00, clk_sec_reg});
        new_dl  = now_s + DL_BITS'(req_reg.ttl_seconds);
        expired = r_has && (now_s >= r_dl);
        has_ttl = req_reg.ttl_seconds > 0;
        scan_prev = cnt_reg - 1'b1;
        scan_hit = (state_reg == ST_SCAN) && (cnt_reg != '0) && !found_reg
                   && valid_reg[scan_prev[IW-1:0]]
                   && (r_key == req_reg.key[KEY_BITS-1:0]);
    end

    // lru and free slot search over ranks
    logic [IW-1:0] lru_idx, free_idx;
    logic          any_valid, any_free;
    always_comb
    begin
        lru_idx = '0; free_idx = '0; any_free = 1'b0;
        any_valid = |valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            // live ranks run 0..live-1, the lru entry holds the top one
            if (valid_reg[i] && CW'(rank_reg[i]) == live_reg - 1'b1)
            begin
                lru_idx = IW'(i);
            end
            if (!valid_reg[i] && !any_free)
            begin
                free_idx = IW'(i); any_free = 1'b1;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // memory port control
    always_comb
    begin
        raddr = cnt_reg[IW-1:0];
        if ((state_reg == ST_SCAN && found_reg) || state_reg == ST_ACT
            || state_reg == ST_RANK) raddr = hit_reg;
        if (state_reg == ST_LRU) raddr = lru_idx;
        if (state_reg == ST_LRUCHK) raddr = tgt_reg;
        we = 1'b0; waddr = hit_reg;
        wdata = {req_reg.key[KEY_BITS-1:0], req_reg.value[VALUE_BITS-1:0],
                 has_ttl, has_ttl ? new_dl : DL_BITS'(0)};
        if (state_reg == ST_ACT && found_reg && !expired
            && req_reg.operation == OP_EXPIRE)
        begin
            we = 1'b1;
            wdata = {r_key, r_val, 1'b1, new_dl};
        end
        if (state_reg == ST_ACT && found_reg && !expired && req_reg.operation == OP_SET)
            we = 1'b1;
        if (state_reg == ST_INS)
        begin
            we = 1'b1; waddr = free_idx;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = (req.operation == OP_TICK) ? ST_DONE : ST_SCAN;
            ST_SCAN:
            begin
                if (found_reg || (cnt_reg == (IW+1)'(ENTRIES) && !scan_hit))
                    state_next = ST_ACT;
            end
            ST_ACT:    state_next = ST_RANK;
            ST_RANK:   state_next = ins_reg ? ST_LRU : ST_DONE;
            ST_LRU:    state_next = ST_LRUCHK;
            ST_LRUCHK: state_next = ST_FREE;
            // keep sweeping while the lru is expired, or evict down to the limit
            ST_FREE:
            begin
                if (any_valid && (32'(live_reg) >= 32'(lim)
                    || (sweep_reg && !valid_reg[tgt_reg])))
                    state_next = ST_LRU;
                else
                    state_next = ST_INS;
            end
            ST_INS:    state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; cfg_reg <= 5'd16; clk_sec_reg <= '0; live_reg <= '0;
            valid_reg <= '0; cnt_reg <= '0; found_reg <= 1'b0; done_reg <= 1'b0;
            rm_reg <= 1'b0; ins_reg <= 1'b0; hit_reg <= '0; tgt_reg <= '0;
            sweep_reg <= 1'b0; req_reg <= '0; rsp_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we) cfg_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req; cnt_reg <= '0; found_reg <= 1'b0;
                        ins_reg <= 1'b0; rsp_reg <= '0; sweep_reg <= 1'b1;
                        if (req.operation == OP_TICK && clk_sec_reg != 32'hFFFF_FFFF)
                            clk_sec_reg <= clk_sec_reg + 32'd1;
                    end
                end
                // one address per cycle, compare the word read last cycle
                ST_SCAN:
                begin
                    if (scan_hit)
                    begin
                        found_reg <= 1'b1; hit_reg <= scan_prev[IW-1:0];
                    end
                    else if (cnt_reg != (IW+1)'(ENTRIES))
                        cnt_reg <= cnt_reg + 1'b1;
                end
                // act on the hit word, now on the read port
                ST_ACT:
                begin
                    rm_reg <= 1'b0; tgt_reg <= hit_reg;
                    if (!found_reg || expired)
                    begin
                        rm_reg <= found_reg && req_reg.operation != OP_TTL
                                  && req_reg.operation != OP_TYPE;
                        if (req_reg.operation != OP_SET && req_reg.operation != OP_TYPE)
                            rsp_reg.status <= 1'b1;
                        if (req_reg.operation == OP_SET) ins_reg <= 1'b1;
                        if (!found_reg || req_reg.operation == OP_TTL
                            || req_reg.operation == OP_TYPE) tgt_reg <= '1;
                    end
                    else
                    begin
                        case (req_reg.operation)
                            OP_GET: rsp_reg.read_value <= 64'(r_val);
                            OP_DEL: rm_reg <= 1'b1;
                            OP_TTL:
                            begin
                                rsp_reg.remaining_seconds <= r_has ?
                                    32'(r_dl - now_s) : -32'sd1;
                            end
                            OP_TYPE: rsp_reg.present_type <= 1'b1;
                            default: ;
                        endcase
                        if (!(req_reg.operation == OP_GET || req_reg.operation == OP_SET
                              || req_reg.operation == OP_DEL)) tgt_reg <= '1;
                    end
                end
                // apply a touch or a removal to the ranks
                ST_RANK, ST_LRUCHK:
                begin
                    if (state_reg == ST_LRUCHK && (!valid_reg[tgt_reg] || !expired))
                        sweep_reg <= 1'b0;
                    if (state_reg == ST_RANK && tgt_reg == '1 && !rm_reg
                        && !(found_reg && (req_reg.operation == OP_GET
                        || req_reg.operation == OP_SET)))
                        ;
                    else if (rm_reg || (state_reg == ST_LRUCHK))
                    begin
                        if (state_reg == ST_RANK || (valid_reg[tgt_reg]
                            && ((sweep_reg && expired) || 32'(live_reg) >= 32'(lim))))
                        begin
                            for (int j = 0; j < ENTRIES; j++)
                                if (valid_reg[j] && rank_reg[j] > rank_reg[tgt_reg])
                                    rank_reg[j] <= rank_reg[j] - 1'b1;
                            valid_reg[tgt_reg] <= 1'b0;
                            if (live_reg != 0) live_reg <= live_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (valid_reg[j] && rank_reg[j] < rank_reg[tgt_reg])
                                rank_reg[j] <= rank_reg[j] + 1'b1;
                        rank_reg[tgt_reg] <= '0;
                    end
                end
                ST_LRU: tgt_reg <= lru_idx;
                ST_INS:
                begin
                    if (any_free)
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (valid_reg[j]) rank_reg[j] <= rank_reg[j] + 1'b1;
                        rank_reg[free_idx] <= '0; valid_reg[free_idx] <= 1'b1;
                        live_reg <= live_reg + 1'b1;
                    end
                end
                ST_DONE: done_reg <= 1'b1;
                default: ;
            endcase
            state_reg <= state_next;
        end
    end

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= ENTRIES) else $error("live count over depth");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double result");
endmodule
`default_nettype wire

FILE: src/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// entry memory: key, value, deadline flag and deadline, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module lkvc_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64,
    parameter int IW         = 4
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [IW-1:0]         waddr,
    input  wire logic [KEY_BITS+VALUE_BITS+1+lkvc_pkg::DL_BITS-1:0] wdata,
    input  wire logic [IW-1:0]         raddr,
    output      logic [KEY_BITS+VALUE_BITS+1+lkvc_pkg::DL_BITS-1:0] rdata
);
    import lkvc_pkg::*;
    localparam int W = KEY_BITS + VALUE_BITS + 1 + DL_BITS;
    logic [W-1:0] mem [ENTRIES];

    // synchronous write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
